/* design/rrip_pkg.sv */
package rrip_pkg;

   localparam int SETS          = 2048;
   localparam int WAYS          = 16;
   localparam int SET_BITS      = 11;
   localparam int WAY_BITS      = 4;
   localparam int LEADER_SETS   = 64;
   localparam int COUNTER_BITS  = 10;
   localparam int DECAY_PERIOD  = 8192;
   localparam int DECAY_BITS    = 13;
   localparam int HIST_DEPTH    = 4;
   localparam int HIST_BITS     = 2;
   localparam int ADDR_BITS     = 48;
   localparam int EPOCH_BITS    = 8;
   localparam logic [1:0] FAR_AGE = 2'd3;
   localparam logic [COUNTER_BITS-1:0] DUEL_MID = COUNTER_BITS'(1 << (COUNTER_BITS - 1));
   localparam logic [COUNTER_BITS-1:0] DUEL_MAX = COUNTER_BITS'((1 << COUNTER_BITS) - 1);

   // One way of replacement state, packed for a per-set row.
   typedef struct packed {
      logic [1:0] age;
      logic [1:0] reuse;
   } way_state_type;

   typedef way_state_type [WAYS-1:0] set_row_type;

   typedef struct packed {
      logic                  mode;
      logic [SET_BITS-1:0]   set_index;
      logic [WAY_BITS-1:0]   way;
      logic [WAYS-1:0]       valid_mask;
      logic [ADDR_BITS-1:0]  address;
      logic                  hit;
      logic [4:0]            chance;
   } req_type;

   typedef struct packed {
      logic [WAY_BITS-1:0] victim_way;
      logic [1:0]          insert_age;
      logic                stream_seen;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic read;
      logic exec;
      logic rsp_load;
      logic scrub;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } status_type;

endpackage

/* design/rrip_datapath.sv */
module rrip_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rrip_pkg::cmd_type   cmd,
   output rrip_pkg::status_type status,
   input  rrip_pkg::req_type   req_payload,
   output rrip_pkg::rsp_type   rsp_payload
);

   // Per-set memories: ages and reuse counts, dead marks with an epoch tag,
   // address history and the history write slot.
   rrip_pkg::set_row_type                  row_mem  [rrip_pkg::SETS];
   logic [rrip_pkg::WAYS-1:0]              dead_mem [rrip_pkg::SETS];
   logic [rrip_pkg::EPOCH_BITS-1:0]        epoch_mem[rrip_pkg::SETS];
   logic [rrip_pkg::HIST_DEPTH*rrip_pkg::ADDR_BITS-1:0] hist_mem[rrip_pkg::SETS];
   logic [rrip_pkg::HIST_BITS-1:0]         slot_mem [rrip_pkg::SETS];

   rrip_pkg::req_type                      req_ff;
   rrip_pkg::set_row_type                  row_ff;
   logic [rrip_pkg::WAYS-1:0]              dead_rd_ff;
   logic [rrip_pkg::EPOCH_BITS-1:0]        epoch_rd_ff;
   logic [rrip_pkg::HIST_DEPTH*rrip_pkg::ADDR_BITS-1:0] hist_ff;
   logic [rrip_pkg::HIST_BITS-1:0]         slot_ff;
   logic [rrip_pkg::EPOCH_BITS-1:0]        epoch_ff, epoch_in;
   logic [rrip_pkg::DECAY_BITS-1:0]        count_ff, count_in;
   logic [rrip_pkg::COUNTER_BITS-1:0]      duel_ff, duel_in;
   logic [rrip_pkg::SET_BITS:0]            clr_ff;
   logic [rrip_pkg::SET_BITS-1:0]          scrub_ff;
   logic [rrip_pkg::EPOCH_BITS-1:0]        scrub_epoch_ff;
   rrip_pkg::rsp_type                      rsp_ff, rsp_in;

   rrip_pkg::set_row_type                  row_new;
   logic [rrip_pkg::WAYS-1:0]              dead_cur, dead_new;
   logic [rrip_pkg::HIST_DEPTH*rrip_pkg::ADDR_BITS-1:0] hist_new;
   logic                                   wr_en;

   assign status.clear_done = clr_ff[rrip_pkg::SET_BITS];
   assign rsp_payload = rsp_ff;
   // Dead marks from an older epoch have been decayed.
   assign dead_cur = (epoch_rd_ff == epoch_ff) ? dead_rd_ff : '0;

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !clr_ff[rrip_pkg::SET_BITS]) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Scrub pointer: walks the sets so that no epoch tag is left behind long
   // enough to alias when the epoch counter wraps.
   always_ff @(posedge clock) begin
      if (reset) begin
         scrub_ff <= '0;
      end else if (cmd.scrub) begin
         scrub_ff <= scrub_ff + 1'b1;
      end
   end

   // Memory access: one row read (plus the scrub set's epoch tag), one row write.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         for (int w = 0; w < rrip_pkg::WAYS; w++) begin
            row_mem[clr_ff[rrip_pkg::SET_BITS-1:0]][w] <= '{age: 2'd3, reuse: 2'd1};
         end
         dead_mem[clr_ff[rrip_pkg::SET_BITS-1:0]]  <= '0;
         epoch_mem[clr_ff[rrip_pkg::SET_BITS-1:0]] <= '0;
         hist_mem[clr_ff[rrip_pkg::SET_BITS-1:0]]  <= '0;
         slot_mem[clr_ff[rrip_pkg::SET_BITS-1:0]]  <= '0;
      end else if (wr_en) begin
         row_mem[req_ff.set_index]   <= row_new;
         dead_mem[req_ff.set_index]  <= dead_new;
         epoch_mem[req_ff.set_index] <= epoch_in;
         hist_mem[req_ff.set_index]  <= hist_new;
         slot_mem[req_ff.set_index]  <= req_ff.mode && !req_ff.hit ? slot_ff + 1'b1 : slot_ff;
      end else if (cmd.scrub && scrub_ff != req_ff.set_index
                   && scrub_epoch_ff != epoch_ff) begin
         // A stale set has its decayed marks cleared under the current epoch.
         dead_mem[scrub_ff]  <= '0;
         epoch_mem[scrub_ff] <= epoch_ff;
      end
      if (cmd.read) begin
         row_ff         <= row_mem[req_ff.set_index];
         dead_rd_ff     <= dead_mem[req_ff.set_index];
         epoch_rd_ff    <= epoch_mem[req_ff.set_index];
         hist_ff        <= hist_mem[req_ff.set_index];
         slot_ff        <= slot_mem[req_ff.set_index];
         scrub_epoch_ff <= epoch_mem[scrub_ff];
      end
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Global counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= '0;
         count_ff <= '0;
         duel_ff  <= rrip_pkg::DUEL_MID;
      end else begin
         epoch_ff <= epoch_in;
         count_ff <= count_in;
         duel_ff  <= duel_in;
      end
   end

   // Execute step: victim search or state update on the fetched set row.
   always_comb begin
      logic [1:0]  oldest;
      logic [1:0]  ins;
      logic        found;
      logic [rrip_pkg::ADDR_BITS-1:0] h0, h1, h2, h3;
      logic [rrip_pkg::ADDR_BITS:0]   d1, d2, d3;
      logic        strm;
      row_new  = row_ff;
      dead_new = dead_cur;
      hist_new = hist_ff;
      epoch_in = epoch_ff;
      count_in = count_ff;
      duel_in  = duel_ff;
      rsp_in   = '0;
      wr_en    = cmd.exec;
      oldest   = '0;
      ins      = 2'd2;
      found    = 1'b0;
      strm     = 1'b0;
      h0 = '0; h1 = '0; h2 = '0; h3 = '0; d1 = '0; d2 = '0; d3 = '0;
      if (!req_ff.mode) begin
         // First invalid way, then first dead way, then first oldest way.
         for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
            if (row_ff[w].age > oldest) oldest = row_ff[w].age;
         end
         for (int w = 0; w < rrip_pkg::WAYS; w++) begin
            row_new[w].age = row_ff[w].age + (2'd3 - oldest);
         end
         for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
            if (row_ff[w].age == oldest) rsp_in.victim_way = rrip_pkg::WAY_BITS'(w);
         end
         for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
            if (dead_cur[w]) begin
               rsp_in.victim_way = rrip_pkg::WAY_BITS'(w);
               found = 1'b1;
            end
         end
         for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
            if (!req_ff.valid_mask[w]) begin
               rsp_in.victim_way = rrip_pkg::WAY_BITS'(w);
               found = 1'b1;
            end
         end
         if (found) row_new = row_ff;
      end else begin
         // Decay: a new epoch makes every stored dead mark stale.
         if (count_ff == rrip_pkg::DECAY_BITS'(rrip_pkg::DECAY_PERIOD - 1)) begin
            count_in = '0;
            epoch_in = epoch_ff + 1'b1;
            dead_new = '0;
         end else begin
            count_in = count_ff + 1'b1;
         end
         if (req_ff.hit) begin
            row_new[req_ff.way].age = 2'd0;
            if (row_ff[req_ff.way].reuse != 2'd3)
               row_new[req_ff.way].reuse = row_ff[req_ff.way].reuse + 1'b1;
            dead_new[req_ff.way] = 1'b0;
         end else begin
            hist_new[slot_ff*rrip_pkg::ADDR_BITS +: rrip_pkg::ADDR_BITS] = req_ff.address;
            h0 = hist_new[0*rrip_pkg::ADDR_BITS +: rrip_pkg::ADDR_BITS];
            h1 = hist_new[1*rrip_pkg::ADDR_BITS +: rrip_pkg::ADDR_BITS];
            h2 = hist_new[2*rrip_pkg::ADDR_BITS +: rrip_pkg::ADDR_BITS];
            h3 = hist_new[3*rrip_pkg::ADDR_BITS +: rrip_pkg::ADDR_BITS];
            // Strides are exact signed differences, one bit wider than an address.
            d1 = {1'b0, h1} - {1'b0, h0};
            d2 = {1'b0, h2} - {1'b0, h1};
            d3 = {1'b0, h3} - {1'b0, h2};
            strm = (slot_ff == 2'd3) && (d1 == d2) && (d1 == d3) && (d1 != '0);
            if (req_ff.set_index < rrip_pkg::SET_BITS'(rrip_pkg::LEADER_SETS / 2))
               ins = 2'd2;
            else if (req_ff.set_index < rrip_pkg::SET_BITS'(rrip_pkg::LEADER_SETS)
                     || duel_ff < rrip_pkg::DUEL_MID)
               ins = (req_ff.chance == '0) ? 2'd2 : 2'd3;
            if (row_ff[req_ff.way].reuse >= 2'd2) ins = 2'd0;
            // A decay in this same update has already cleared the mark.
            if (dead_new[req_ff.way]) ins = 2'd3;
            if (strm) ins = rrip_pkg::FAR_AGE;
            row_new[req_ff.way].age   = ins;
            row_new[req_ff.way].reuse = 2'd1;
            dead_new[req_ff.way]      = 1'b1;
            if (req_ff.set_index < rrip_pkg::SET_BITS'(rrip_pkg::LEADER_SETS / 2)) begin
               if (duel_ff != '0) duel_in = duel_ff - 1'b1;
            end else if (req_ff.set_index < rrip_pkg::SET_BITS'(rrip_pkg::LEADER_SETS)) begin
               if (duel_ff != rrip_pkg::DUEL_MAX) duel_in = duel_ff + 1'b1;
            end
            rsp_in.insert_age  = ins;
            rsp_in.stream_seen = strm;
         end
      end
      if (!cmd.exec) begin
         epoch_in = epoch_ff;
         count_in = count_ff;
         duel_in  = duel_ff;
      end
   end

endmodule

/* design/rrip_controller.sv */
module rrip_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rrip_pkg::status_type status,
   output rrip_pkg::cmd_type    cmd
);

   rrip_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= rrip_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rrip_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = rrip_pkg::ST_IDLE;
         end
         rrip_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = 1'b1;
            if (req_valid) state_in = rrip_pkg::ST_READ;
         end
         rrip_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = rrip_pkg::ST_EXEC;
         end
         rrip_pkg::ST_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.rsp_load = 1'b1;
            state_in     = rrip_pkg::ST_OUT;
         end
         rrip_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            // One set is scrubbed as the response leaves.
            cmd.scrub = !rsp_stall;
            if (!rsp_stall) state_in = rrip_pkg::ST_IDLE;
         end
         default: state_in = rrip_pkg::ST_IDLE;
      endcase
   end

endmodule

/* design/rrip_dueling_replacement_policy.sv */
// RRIP replacement engine with set dueling, dead marks and stride detection.
// Each request goes through these steps, the last held by any output stall: accept, read the set row
// from the per-set memories, evaluate and write back, then present the response.
// After reset a clearing pass (one set per cycle) initializes the memories; no request is
// accepted during it. Dead-mark decay is done with an epoch tag per set, so the periodic
// clear is a single epoch increment; as each response leaves, one set in turn with a stale
// tag has its marks cleared, so tags never alias when the epoch counter wraps.
module rrip_dueling_replacement_policy (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrip_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrip_pkg::rsp_type rsp_payload
);

   rrip_pkg::cmd_type    cmd;
   rrip_pkg::status_type status;

   rrip_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd)
   );

   rrip_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_payload(req_payload), .rsp_payload(rsp_payload)
   );

   // A response is never offered while a request can be taken.
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && !req_stall))
      else $error("response and request overlap");

   // An accepted request leads to a response after the read and execute states.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##2 rsp_valid)
      else $error("response missing");

endmodule
